>>> src/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

	localparam logic [7:0]  LEGACY_SYNC0 = 8'hAA;
	localparam logic [7:0]  LEGACY_SYNC1 = 8'hFF;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'h1021;
	localparam logic [4:0]  LEGACY_LEN   = 5'd8;
	localparam logic [4:0]  FIXED_LEN    = 5'd11;

	// byte offsets inside a frame
	localparam logic [4:0] OFS_VERSION = 5'd2;
	localparam logic [4:0] OFS_CMD     = 5'd3;
	localparam logic [4:0] OFS_SEQ     = 5'd4;
	localparam logic [4:0] OFS_OBJ_LO  = 5'd5;
	localparam logic [4:0] OFS_OBJ_HI  = 5'd6;
	localparam logic [4:0] OFS_PAR_LO  = 5'd7;
	localparam logic [4:0] OFS_PAR_HI  = 5'd8;
	localparam logic [4:0] OFS_TYPE    = 5'd9;
	localparam logic [4:0] OFS_LEN     = 5'd10;
	localparam logic [4:0] COUNT_MAX   = 5'd31;

	localparam logic [1:0] EV_COMMAND   = 2'd0;
	localparam logic [1:0] EV_CRC_ERROR = 2'd1;
	localparam logic [1:0] EV_TIMEOUT   = 2'd2;

	localparam logic [2:0] REG_HDR_FIRST   = 3'd0;
	localparam logic [2:0] REG_HDR_SECOND  = 3'd1;
	localparam logic [2:0] REG_VERSION     = 3'd2;
	localparam logic [2:0] REG_TICK_LIMIT  = 3'd3;
	localparam logic [2:0] REG_LEGACY_CODE = 3'd4;
	localparam logic [2:0] REG_LEGACY_TYPE = 3'd5;
	localparam logic [2:0] REG_LEGACY_EN   = 3'd6;
	localparam logic [2:0] REG_NEW_EN      = 3'd7;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [7:0]  RST_HDR_FIRST   = 8'hA5;
	localparam logic [7:0]  RST_HDR_SECOND  = 8'h5A;
	localparam logic [7:0]  RST_VERSION     = 8'h01;
	localparam logic [15:0] RST_TICK_LIMIT  = 16'd100;
	localparam logic [7:0]  RST_LEGACY_CODE = 8'h01;
	localparam logic [7:0]  RST_LEGACY_TYPE = 8'h00;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEG_SYNC1,
		ST_LEG_OBJ,
		ST_LEG_PAR,
		ST_LEG_VAL,
		ST_NEW_HDR2,
		ST_NEW_FIXED,
		ST_NEW_PAY,
		ST_NEW_CRC_LO,
		ST_NEW_CRC_HI
	} parse_state_t;

	typedef struct packed {
		logic [7:0]  new_header_first;
		logic [7:0]  new_header_second;
		logic [7:0]  protocol_version;
		logic [15:0] idle_tick_limit;
		logic [7:0]  legacy_write_code;
		logic [7:0]  legacy_float_type;
		logic        legacy_enable;
		logic        new_enable;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  command_code;
		logic [7:0]  sequence_number;
		logic [15:0] object_number;
		logic [15:0] parameter_number;
		logic [7:0]  type_code;
		logic [2:0]  payload_length;
		logic [31:0] payload_word;
		logic        is_new_format;
	} res_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
		end
		return x;
	endfunction

endpackage

`default_nettype wire

>>> src/cfp_rx_if.sv
`default_nettype none

interface cfp_rx_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] byte_value;

	modport source (output valid, output mode, output byte_value, input ready);
	modport sink (input valid, input mode, input byte_value, output ready);
endinterface

`default_nettype wire

>>> src/cfp_evt_if.sv
`default_nettype none

interface cfp_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [7:0]  command_code;
	logic [7:0]  sequence_number;
	logic [15:0] object_number;
	logic [15:0] parameter_number;
	logic [7:0]  type_code;
	logic [2:0]  payload_length;
	logic [31:0] payload_word;
	logic        is_new_format;

	modport source (
		output valid, output event_res, output command_code, output sequence_number,
		output object_number, output parameter_number, output type_code,
		output payload_length, output payload_word, output is_new_format,
		input ready
	);
	modport sink (
		input valid, input event_res, input command_code, input sequence_number,
		input object_number, input parameter_number, input type_code,
		input payload_length, input payload_word, input is_new_format,
		output ready
	);
endinterface

`default_nettype wire

>>> src/cfp_cfg_regs.sv
`default_nettype none

module cfp_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [cfp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [cfp_pkg::CFG_DATA_W-1:0]      cfg_data,
	output cfp_pkg::cfg_t                            cfg
);

	cfp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.new_header_first  <= cfp_pkg::RST_HDR_FIRST;
			cfg_q.new_header_second <= cfp_pkg::RST_HDR_SECOND;
			cfg_q.protocol_version  <= cfp_pkg::RST_VERSION;
			cfg_q.idle_tick_limit   <= cfp_pkg::RST_TICK_LIMIT;
			cfg_q.legacy_write_code <= cfp_pkg::RST_LEGACY_CODE;
			cfg_q.legacy_float_type <= cfp_pkg::RST_LEGACY_TYPE;
			cfg_q.legacy_enable     <= 1'b1;
			cfg_q.new_enable        <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				cfp_pkg::REG_HDR_FIRST:   cfg_q.new_header_first  <= cfg_data[7:0];
				cfp_pkg::REG_HDR_SECOND:  cfg_q.new_header_second <= cfg_data[7:0];
				cfp_pkg::REG_VERSION:     cfg_q.protocol_version  <= cfg_data[7:0];
				cfp_pkg::REG_TICK_LIMIT:  cfg_q.idle_tick_limit   <= cfg_data;
				cfp_pkg::REG_LEGACY_CODE: cfg_q.legacy_write_code <= cfg_data[7:0];
				cfp_pkg::REG_LEGACY_TYPE: cfg_q.legacy_float_type <= cfg_data[7:0];
				cfp_pkg::REG_LEGACY_EN:   cfg_q.legacy_enable     <= cfg_data[0];
				cfp_pkg::REG_NEW_EN:      cfg_q.new_enable        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> src/cfp_parser.sv
`default_nettype none

module cfp_parser #(
	parameter int unsigned PAYLOAD_MAX = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic          mode,
	input  wire logic [7:0]    byte_value,
	input  wire cfp_pkg::cfg_t cfg,
	output logic               res_valid,
	output cfp_pkg::res_t      res
);

	cfp_pkg::parse_state_t state_q, state_d;
	logic [4:0]  count_q, count_d;
	logic [2:0]  exp_q, exp_d;
	logic [15:0] idle_q, idle_d;
	logic [15:0] crc_q, crc_d;

	logic [7:0]  ver_q, ver_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  seq_q, seq_d;
	logic [15:0] obj_q, obj_d;
	logic [15:0] par_q, par_d;
	logic [7:0]  type_q, type_d;
	logic [31:0] word_q, word_d;
	logic [7:0]  crc_lo_q, crc_lo_d;

	logic        abort;
	logic [4:0]  count_inc;
	logic [4:0]  pay_ofs;
	logic [15:0] crc_next;

	assign count_inc = (count_q == cfp_pkg::COUNT_MAX) ? count_q : count_q + 5'd1;
	assign pay_ofs   = count_q - cfp_pkg::FIXED_LEN;
	assign crc_next  = cfp_pkg::crc_byte(crc_q, byte_value);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		exp_d     = exp_q;
		idle_d    = idle_q;
		crc_d     = crc_q;
		ver_d     = ver_q;
		cmd_d     = cmd_q;
		seq_d     = seq_q;
		obj_d     = obj_q;
		par_d     = par_q;
		type_d    = type_q;
		word_d    = word_q;
		crc_lo_d  = crc_lo_q;
		abort     = 1'b0;
		res_valid = 1'b0;
		res       = '0;

		if (step) begin
			if (mode) begin
				if (state_q != cfp_pkg::ST_IDLE) begin
					idle_d = idle_q + 16'd1;
					if (idle_d > cfg.idle_tick_limit) begin
						abort         = 1'b1;
						res_valid     = 1'b1;
						res.event_res = cfp_pkg::EV_TIMEOUT;
					end
				end
			end else begin
				idle_d = '0;
				if ((state_q inside {cfp_pkg::ST_LEG_SYNC1, cfp_pkg::ST_LEG_OBJ,
						cfp_pkg::ST_LEG_PAR, cfp_pkg::ST_LEG_VAL}) && !cfg.legacy_enable) begin
					abort = 1'b1;
				end else if ((state_q inside {cfp_pkg::ST_NEW_HDR2, cfp_pkg::ST_NEW_FIXED,
						cfp_pkg::ST_NEW_PAY, cfp_pkg::ST_NEW_CRC_LO,
						cfp_pkg::ST_NEW_CRC_HI}) && !cfg.new_enable) begin
					abort = 1'b1;
				end else begin
					case (state_q)
						cfp_pkg::ST_IDLE: begin
							if (cfg.legacy_enable && byte_value == cfp_pkg::LEGACY_SYNC0) begin
								count_d = 5'd1;
								state_d = cfp_pkg::ST_LEG_SYNC1;
							end else if (cfg.new_enable && byte_value == cfg.new_header_first) begin
								count_d = 5'd1;
								crc_d   = cfp_pkg::crc_byte(cfp_pkg::CRC_INIT, byte_value);
								word_d  = '0;
								state_d = cfp_pkg::ST_NEW_HDR2;
							end
						end
						cfp_pkg::ST_LEG_SYNC1: begin
							if (byte_value == cfp_pkg::LEGACY_SYNC1) begin
								count_d = count_inc;
								state_d = cfp_pkg::ST_LEG_OBJ;
							end else begin
								abort = 1'b1;
							end
						end
						cfp_pkg::ST_LEG_OBJ: begin
							count_d = count_inc;
							obj_d   = {8'h00, byte_value};
							state_d = cfp_pkg::ST_LEG_PAR;
						end
						cfp_pkg::ST_LEG_PAR: begin
							count_d = count_inc;
							par_d   = {8'h00, byte_value};
							state_d = cfp_pkg::ST_LEG_VAL;
						end
						cfp_pkg::ST_LEG_VAL: begin
							count_d = count_inc;
							word_d[count_q[1:0]*8 +: 8] = byte_value;
							if (count_inc >= cfp_pkg::LEGACY_LEN) begin
								abort                = 1'b1;
								res_valid            = 1'b1;
								res.event_res        = cfp_pkg::EV_COMMAND;
								res.command_code     = cfg.legacy_write_code;
								res.object_number    = obj_d;
								res.parameter_number = par_d;
								res.type_code        = cfg.legacy_float_type;
								res.payload_length   = 3'd4;
								res.payload_word     = word_d;
							end
						end
						cfp_pkg::ST_NEW_HDR2: begin
							if (byte_value == cfg.new_header_second) begin
								count_d = count_inc;
								crc_d   = crc_next;
								state_d = cfp_pkg::ST_NEW_FIXED;
							end else begin
								abort = 1'b1;
							end
						end
						cfp_pkg::ST_NEW_FIXED: begin
							count_d = count_inc;
							crc_d   = crc_next;
							case (count_q)
								cfp_pkg::OFS_VERSION: ver_d = byte_value;
								cfp_pkg::OFS_CMD:     cmd_d = byte_value;
								cfp_pkg::OFS_SEQ:     seq_d = byte_value;
								cfp_pkg::OFS_OBJ_LO:  obj_d[7:0] = byte_value;
								cfp_pkg::OFS_OBJ_HI:  obj_d[15:8] = byte_value;
								cfp_pkg::OFS_PAR_LO:  par_d[7:0] = byte_value;
								cfp_pkg::OFS_PAR_HI:  par_d[15:8] = byte_value;
								cfp_pkg::OFS_TYPE:    type_d = byte_value;
								default: ;
							endcase
							if (count_q == cfp_pkg::OFS_LEN) begin
								if (ver_q != cfg.protocol_version
										|| byte_value > 8'(PAYLOAD_MAX)) begin
									abort = 1'b1;
								end else begin
									exp_d   = byte_value[2:0];
									state_d = (byte_value == 8'h00) ? cfp_pkg::ST_NEW_CRC_LO
										: cfp_pkg::ST_NEW_PAY;
								end
							end
						end
						cfp_pkg::ST_NEW_PAY: begin
							count_d = count_inc;
							crc_d   = crc_next;
							word_d[pay_ofs[1:0]*8 +: 8] = byte_value;
							if (count_inc >= cfp_pkg::FIXED_LEN + {2'b00, exp_q}) begin
								state_d = cfp_pkg::ST_NEW_CRC_LO;
							end
						end
						cfp_pkg::ST_NEW_CRC_LO: begin
							count_d  = count_inc;
							crc_lo_d = byte_value;
							state_d  = cfp_pkg::ST_NEW_CRC_HI;
						end
						cfp_pkg::ST_NEW_CRC_HI: begin
							abort     = 1'b1;
							res_valid = 1'b1;
							res.is_new_format = 1'b1;
							if ({byte_value, crc_lo_q} != crc_q) begin
								res.event_res = cfp_pkg::EV_CRC_ERROR;
							end else begin
								res.event_res        = cfp_pkg::EV_COMMAND;
								res.command_code     = cmd_q;
								res.sequence_number  = seq_q;
								res.object_number    = obj_q;
								res.parameter_number = par_q;
								res.type_code        = type_q;
								res.payload_length   = exp_q;
								res.payload_word     = word_q;
							end
						end
						default: abort = 1'b1;
					endcase
				end
			end
		end

		if (abort) begin
			state_d = cfp_pkg::ST_IDLE;
			count_d = '0;
			exp_d   = '0;
			idle_d  = '0;
			crc_d   = cfp_pkg::CRC_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfp_pkg::ST_IDLE;
			count_q <= '0;
			exp_q   <= '0;
			idle_q  <= '0;
			crc_q   <= cfp_pkg::CRC_INIT;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			exp_q   <= exp_d;
			idle_q  <= idle_d;
			crc_q   <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		ver_q    <= ver_d;
		cmd_q    <= cmd_d;
		seq_q    <= seq_d;
		obj_q    <= obj_d;
		par_q    <= par_d;
		type_q   <= type_d;
		word_q   <= word_d;
		crc_lo_q <= crc_lo_d;
	end

endmodule

`default_nettype wire

>>> src/command_frame_parser_crc16_unit.sv
// Serial command frame parser with CRC16-CCITT-FALSE check.
// rx channel: one request per received byte (mode 0) or idle tick (mode 1).
// evt channel: command frames, CRC-error events and receive timeouts, at
// most one per request; most requests give none.
// Configuration: cfg_we/cfg_index/cfg_data write one of eight registers
// (header bytes, version, idle tick limit, legacy code and type, enables);
// write only while the parser has nothing in flight.
// Path: a request taken on rx is registered in the input stage, decoded by the
// parser, and its result is registered in the result stage that drives evt.
// Throughput: one request per cycle unless evt stalls; the CRC update of one
// byte is one combinational step from input register to the CRC register.
// Reset: parser idle, CRC at 0xFFFF, registers at their defaults, both
// channel stages empty.
// Stall: when evt holds a result that is not taken, rx.ready drops and both
// stages hold; a cycle without a pending result keeps rx.ready high.
`default_nettype none

module command_frame_parser_crc16_unit #(
	parameter int unsigned PAYLOAD_MAX = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [cfp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [cfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	cfp_rx_if.sink                               rx,
	cfp_evt_if.source                            evt
);

	cfp_pkg::cfg_t cfg;
	cfp_pkg::res_t p_res;
	cfp_pkg::res_t res_q;
	logic          p_valid;
	logic          res_valid_q;
	logic          valid_s1;
	logic          mode_s1;
	logic [7:0]    byte_s1;
	logic          advance;

	assign advance  = !res_valid_q || evt.ready;
	assign rx.ready = advance;

	cfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cfp_parser #(
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (valid_s1 && advance),
		.mode       (mode_s1),
		.byte_value (byte_s1),
		.cfg        (cfg),
		.res_valid  (p_valid),
		.res        (p_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= rx.valid;
			res_valid_q <= p_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s1 <= rx.mode;
			byte_s1 <= rx.byte_value;
			res_q   <= p_res;
		end
	end

	assign evt.valid            = res_valid_q;
	assign evt.event_res        = res_q.event_res;
	assign evt.command_code     = res_q.command_code;
	assign evt.sequence_number  = res_q.sequence_number;
	assign evt.object_number    = res_q.object_number;
	assign evt.parameter_number = res_q.parameter_number;
	assign evt.type_code        = res_q.type_code;
	assign evt.payload_length   = res_q.payload_length;
	assign evt.payload_word     = res_q.payload_word;
	assign evt.is_new_format    = res_q.is_new_format;

	a_timeout_clean: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.event_res == cfp_pkg::EV_TIMEOUT
			|-> !evt.is_new_format && evt.payload_word == '0 && evt.command_code == '0)
		else $error("timeout event carries frame data");

	a_crc_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.event_res == cfp_pkg::EV_CRC_ERROR
			|-> evt.is_new_format && evt.payload_length == '0 && evt.object_number == '0)
		else $error("CRC error event malformed");

	a_legacy_len: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.event_res == cfp_pkg::EV_COMMAND && !evt.is_new_format
			|-> evt.payload_length == 3'd4 && evt.sequence_number == '0)
		else $error("legacy command with wrong length or sequence");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.is_new_format |-> evt.payload_length <= 3'(PAYLOAD_MAX))
		else $error("payload length above limit");

	a_no_event_code3: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |-> evt.event_res != 2'd3)
		else $error("undefined event code");

endmodule

`default_nettype wire

>>> bench/command_frame_parser_crc16_unit_tb.sv
module command_frame_parser_crc16_unit_tb;
	import cfp_pkg::*;

	localparam int PAY_MAX        = 4;
	localparam int STORE_BYTES    = 17;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF       = 400;
	localparam int SETTLE_CYCLES  = 4;

	class frame_scoreboard;
		cfg_t         regs;
		parse_state_t state;
		logic [4:0]   count;
		logic [2:0]   pay_len;
		logic [15:0]  ticks;
		logic [15:0]  crc;
		logic [7:0]   frame[STORE_BYTES];
		res_t         pending[$];
		int           errors;

		function new();
			regs.new_header_first = RST_HDR_FIRST;
			regs.new_header_second = RST_HDR_SECOND;
			regs.protocol_version = RST_VERSION;
			regs.idle_tick_limit = RST_TICK_LIMIT;
			regs.legacy_write_code = RST_LEGACY_CODE;
			regs.legacy_float_type = RST_LEGACY_TYPE;
			regs.legacy_enable = 1'b1;
			regs.new_enable = 1'b1;
			foreach (frame[i])
				frame[i] = 8'h00;
			errors = 0;
			restart();
		endfunction

		static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ b[i];
				c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
			end
			return c;
		endfunction

		function void restart();
			state = ST_IDLE;
			count = '0;
			pay_len = '0;
			ticks = '0;
			crc = CRC_INIT;
		endfunction

		function void put(logic [7:0] b);
			if (count < STORE_BYTES)
				frame[count] = b;
			if (count < COUNT_MAX)
				count++;
		endfunction

		function logic [7:0] stored(int unsigned i);
			return (i < STORE_BYTES) ? frame[i] : 8'h00;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_HDR_FIRST:   regs.new_header_first = val[7:0];
				REG_HDR_SECOND:  regs.new_header_second = val[7:0];
				REG_VERSION:     regs.protocol_version = val[7:0];
				REG_TICK_LIMIT:  regs.idle_tick_limit = val;
				REG_LEGACY_CODE: regs.legacy_write_code = val[7:0];
				REG_LEGACY_TYPE: regs.legacy_float_type = val[7:0];
				REG_LEGACY_EN:   regs.legacy_enable = val[0];
				REG_NEW_EN:      regs.new_enable = val[0];
				default: ;
			endcase
		endfunction

		function void note_request(logic m, logic [7:0] b);
			res_t        r;
			logic [7:0]  len_byte;
			logic [15:0] rx_crc;
			int unsigned crc_at;
			r = '0;
			if (m) begin
				if (state == ST_IDLE)
					return;
				ticks++;
				if (ticks > regs.idle_tick_limit) begin
					restart();
					r.event_res = EV_TIMEOUT;
					pending.push_back(r);
				end
				return;
			end
			ticks = '0;
			if ((state >= ST_LEG_SYNC1 && state <= ST_LEG_VAL && !regs.legacy_enable) ||
			    (state >= ST_NEW_HDR2 && state <= ST_NEW_CRC_HI && !regs.new_enable)) begin
				restart();
				return;
			end
			case (state)
				ST_IDLE: begin
					if (regs.legacy_enable && b == LEGACY_SYNC0) begin
						count = '0;
						put(b);
						state = ST_LEG_SYNC1;
					end else if (regs.new_enable && b == regs.new_header_first) begin
						count = '0;
						put(b);
						crc = crc_next(CRC_INIT, b);
						state = ST_NEW_HDR2;
					end
				end
				ST_LEG_SYNC1: begin
					if (b == LEGACY_SYNC1) begin
						put(b);
						state = ST_LEG_OBJ;
					end else
						restart();
				end
				ST_LEG_OBJ: begin
					put(b);
					state = ST_LEG_PAR;
				end
				ST_LEG_PAR: begin
					put(b);
					state = ST_LEG_VAL;
				end
				ST_LEG_VAL: begin
					put(b);
					if (count >= LEGACY_LEN) begin
						r.event_res = EV_COMMAND;
						r.command_code = regs.legacy_write_code;
						r.object_number = {8'h00, stored(2)};
						r.parameter_number = {8'h00, stored(3)};
						r.type_code = regs.legacy_float_type;
						r.payload_length = 3'd4;
						r.payload_word = {stored(7), stored(6), stored(5), stored(4)};
						pending.push_back(r);
						restart();
					end
				end
				ST_NEW_HDR2: begin
					if (b == regs.new_header_second) begin
						put(b);
						crc = crc_next(crc, b);
						state = ST_NEW_FIXED;
					end else
						restart();
				end
				ST_NEW_FIXED: begin
					put(b);
					crc = crc_next(crc, b);
					if (count == FIXED_LEN) begin
						len_byte = stored(OFS_LEN);
						if (stored(OFS_VERSION) != regs.protocol_version || len_byte > PAY_MAX)
							restart();
						else begin
							pay_len = len_byte[2:0];
							state = (pay_len == 0) ? ST_NEW_CRC_LO : ST_NEW_PAY;
						end
					end
				end
				ST_NEW_PAY: begin
					put(b);
					crc = crc_next(crc, b);
					if (count >= FIXED_LEN + pay_len)
						state = ST_NEW_CRC_LO;
				end
				ST_NEW_CRC_LO: begin
					put(b);
					state = ST_NEW_CRC_HI;
				end
				ST_NEW_CRC_HI: begin
					put(b);
					crc_at = FIXED_LEN + pay_len;
					rx_crc = {stored(crc_at + 1), stored(crc_at)};
					if (rx_crc != crc) begin
						r.event_res = EV_CRC_ERROR;
						r.is_new_format = 1'b1;
					end else begin
						r.event_res = EV_COMMAND;
						r.command_code = stored(OFS_CMD);
						r.sequence_number = stored(OFS_SEQ);
						r.object_number = {stored(OFS_OBJ_HI), stored(OFS_OBJ_LO)};
						r.parameter_number = {stored(OFS_PAR_HI), stored(OFS_PAR_LO)};
						r.type_code = stored(OFS_TYPE);
						r.payload_length = pay_len;
						for (int i = 0; i < pay_len; i++)
							r.payload_word[8*i +: 8] = stored(FIXED_LEN + i);
						r.is_new_format = 1'b1;
					end
					pending.push_back(r);
					restart();
				end
				default: restart();
			endcase
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] seen);
			if (seen !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, expected nothing, actual %p",
					$time, got);
				return;
			end
			want = pending.pop_front();
			compare("event_res", want.event_res, got.event_res);
			compare("command_code", want.command_code, got.command_code);
			compare("sequence_number", want.sequence_number, got.sequence_number);
			compare("object_number", want.object_number, got.object_number);
			compare("parameter_number", want.parameter_number, got.parameter_number);
			compare("type_code", want.type_code, got.type_code);
			compare("payload_length", want.payload_length, got.payload_length);
			compare("payload_word", want.payload_word, got.payload_word);
			compare("is_new_format", want.is_new_format, got.is_new_format);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	cfp_rx_if  rx_ch ();
	cfp_evt_if evt_ch ();

	command_frame_parser_crc16_unit #(.PAYLOAD_MAX(PAY_MAX)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch),
		.evt       (evt_ch)
	);

	frame_scoreboard sb = new();
	int src_gap_pct = 11;
	int sink_gap_pct = 56;
	int hold_left = 0;
	int sent = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((rx_ch.valid && rx_ch.ready) || (evt_ch.valid && evt_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("command_frame_parser_crc16_unit verification failed");
		$finish;
	end

	initial begin
		evt_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && evt_ch.valid && evt_ch.ready)
				sb.check_result({evt_ch.event_res, evt_ch.command_code, evt_ch.sequence_number,
					evt_ch.object_number, evt_ch.parameter_number, evt_ch.type_code,
					evt_ch.payload_length, evt_ch.payload_word, evt_ch.is_new_format});
			if (hold_left > 0) begin
				hold_left--;
				evt_ch.ready <= 1'b0;
			end else
				evt_ch.ready <= ($urandom_range(99) >= sink_gap_pct);
		end
	end

	task automatic send(logic m, logic [7:0] b);
		if ($urandom_range(99) < src_gap_pct) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.mode <= m;
		rx_ch.byte_value <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		sb.note_request(m, b);
		sent++;
	endtask

	task automatic tick();
		send(1'b1, 8'($urandom));
	endtask

	task automatic send_bytes(logic [7:0] octets[$], bit with_ticks);
		foreach (octets[i]) begin
			if (with_ticks && $urandom_range(19) == 0)
				repeat ($urandom_range(1, 3)) tick();
			send(1'b0, octets[i]);
		end
	endtask

	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic load_config(cfg_t c);
		set_reg(REG_HDR_FIRST, {8'h00, c.new_header_first});
		set_reg(REG_HDR_SECOND, {8'h00, c.new_header_second});
		set_reg(REG_VERSION, {8'h00, c.protocol_version});
		set_reg(REG_TICK_LIMIT, c.idle_tick_limit);
		set_reg(REG_LEGACY_CODE, {8'h00, c.legacy_write_code});
		set_reg(REG_LEGACY_TYPE, {8'h00, c.legacy_float_type});
		set_reg(REG_LEGACY_EN, {15'h0000, c.legacy_enable});
		set_reg(REG_NEW_EN, {15'h0000, c.new_enable});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_traffic(int count);
		logic [7:0]  octets[$];
		logic [15:0] crc;
		int          kind;
		int          len;
		int          stop;
		bit          legacy_ok;
		bit          new_ok;
		stop = sent + count;
		while (sent < stop) begin
			legacy_ok = sb.regs.legacy_enable;
			new_ok = sb.regs.new_enable &&
				!(legacy_ok && sb.regs.new_header_first == LEGACY_SYNC0);
			kind = $urandom_range(99);
			octets.delete();
			if (kind < 70 && (legacy_ok || new_ok)) begin
				if (legacy_ok && (!new_ok || $urandom_range(2) == 0)) begin
					octets = {LEGACY_SYNC0, LEGACY_SYNC1};
					repeat (6) octets.push_back(8'($urandom));
				end else begin
					octets = {sb.regs.new_header_first, sb.regs.new_header_second,
						sb.regs.protocol_version};
					repeat (7) octets.push_back(8'($urandom));
					len = $urandom_range(PAY_MAX);
					octets.push_back(8'(len));
					repeat (len) octets.push_back(8'($urandom));
					crc = CRC_INIT;
					foreach (octets[i])
						crc = frame_scoreboard::crc_next(crc, octets[i]);
					if ($urandom_range(7) == 0)
						crc ^= 16'(1 << $urandom_range(15));
					octets.push_back(crc[7:0]);
					octets.push_back(crc[15:8]);
				end
				if (kind >= 55) begin
					if ($urandom_range(1))
						octets[$urandom_range(1, octets.size() - 1)] = 8'($urandom);
					else
						octets = octets[0:$urandom_range(1, octets.size() - 2)];
				end
				send_bytes(octets, 1'b1);
				if (kind >= 55 && (sb.regs.idle_tick_limit < 8 ||
				    (sb.regs.idle_tick_limit < 150 && $urandom_range(3) == 0)))
					repeat (sb.regs.idle_tick_limit + 1) tick();
			end else if (kind < 85) begin
				repeat ($urandom_range(1, 8)) tick();
			end else begin
				repeat ($urandom_range(1, 6))
					octets.push_back(($urandom_range(3) == 0) ?
						sb.regs.new_header_first : 8'($urandom));
				send_bytes(octets, 1'b0);
			end
		end
	endtask

	initial begin
		cfg_t       c;
		logic [7:0] octets[$];
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		rx_ch.valid <= 1'b0;
		rx_ch.mode <= 1'b0;
		rx_ch.byte_value <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		c.new_header_first = RST_HDR_FIRST;
		c.new_header_second = RST_HDR_SECOND;
		c.protocol_version = RST_VERSION;
		c.idle_tick_limit = 16'd1;
		c.legacy_write_code = RST_LEGACY_CODE;
		c.legacy_float_type = RST_LEGACY_TYPE;
		c.legacy_enable = 1'b1;
		c.new_enable = 1'b1;
		load_config(c);

		tick();
		octets = {LEGACY_SYNC0, LEGACY_SYNC1, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01};
		send_bytes(octets, 1'b0);
		send(1'b0, RST_HDR_FIRST);
		tick();
		send(1'b0, RST_HDR_SECOND);
		tick();
		tick();
		octets = {RST_HDR_FIRST, RST_HDR_SECOND, RST_VERSION, 8'hFF, 8'h00, 8'hFF, 8'h00,
			8'hFF, 8'h00, 8'hFF, 8'h05};
		send_bytes(octets, 1'b0);

		// hold the result side while requests keep coming
		hold_left = HOLD_OFF;
		random_traffic(200);
		repeat (sb.regs.idle_tick_limit + 1) tick();
		octets = {LEGACY_SYNC0, LEGACY_SYNC1, 8'h12};
		send_bytes(octets, 1'b0);
		settle();

		c.legacy_enable = 1'b0;
		c.new_header_first = LEGACY_SYNC0;
		c.new_header_second = 8'h00;
		c.protocol_version = 8'h00;
		c.idle_tick_limit = 16'd0;
		load_config(c);
		random_traffic(205);
		repeat (sb.regs.idle_tick_limit + 1) tick();
		octets = {LEGACY_SYNC0, 8'h00, 8'h00, 8'h7E};
		send_bytes(octets, 1'b0);
		settle();

		src_gap_pct = 56;
		sink_gap_pct = 11;
		c.new_enable = 1'b0;
		c.legacy_enable = 1'b1;
		c.legacy_write_code = 8'hFF;
		c.legacy_float_type = 8'hFF;
		c.idle_tick_limit = 16'hFFFF;
		load_config(c);
		random_traffic(205);
		settle();

		c.new_enable = 1'b1;
		c.new_header_second = 8'hFF;
		c.protocol_version = 8'hFF;
		c.legacy_write_code = 8'h00;
		c.idle_tick_limit = 16'd3;
		load_config(c);
		random_traffic(205);
		settle();

		src_gap_pct = 0;
		sink_gap_pct = 0;
		c.new_header_first = 8'($urandom);
		c.new_header_second = 8'($urandom);
		c.protocol_version = 8'($urandom);
		c.idle_tick_limit = 16'($urandom_range(0, 12));
		c.legacy_write_code = 8'($urandom);
		c.legacy_float_type = 8'($urandom);
		c.legacy_enable = 1'b1;
		c.new_enable = 1'b1;
		load_config(c);
		random_traffic(205);
		settle();

		c.new_header_first = RST_HDR_FIRST;
		c.new_header_second = RST_HDR_SECOND;
		c.protocol_version = RST_VERSION;
		c.idle_tick_limit = RST_TICK_LIMIT;
		c.legacy_write_code = RST_LEGACY_CODE;
		c.legacy_float_type = RST_LEGACY_TYPE;
		load_config(c);
		random_traffic(205);
		settle();

		if (sb.errors == 0)
			$display("command_frame_parser_crc16_unit verification clean");
		else
			$display("command_frame_parser_crc16_unit verification failed");
		$finish;
	end
endmodule

>>> command_frame_parser_crc16_unit.f
src/cfp_pkg.sv
src/cfp_rx_if.sv
src/cfp_evt_if.sv
src/cfp_cfg_regs.sv
src/cfp_parser.sv
src/command_frame_parser_crc16_unit.sv
bench/command_frame_parser_crc16_unit_tb.sv
